### src/hash_join_match_table_macros.svh
// Assertion macros for the hash join match table.
`ifndef HASH_JOIN_MATCH_TABLE_MACROS_SVH
`define HASH_JOIN_MATCH_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define HJM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hash join match table: assertion failed");
`define HJM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hash join match table: next-cycle assertion failed");
`else
`define HJM_ASSERT(lbl, prop)
`define HJM_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### src/hjm_pkg.sv
// Types and constants shared by the hash join match table.
`timescale 1ns / 1ps
package hjm_pkg;

    localparam int HJM_DEPTH = 64;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_PROBE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] RS_STORED  = 3'd0;
    localparam logic [2:0] RS_FULL    = 3'd1;
    localparam logic [2:0] RS_MATCH   = 3'd2;
    localparam logic [2:0] RS_NOMATCH = 3'd3;
    localparam logic [2:0] RS_CLEARED = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_hash;
        logic [15:0] region_id;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] delete_id;
        logic [15:0] insert_id;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [63:0] key_hash;
        logic [15:0] region_id;
    } entry_t;

    typedef struct packed {
        logic wen;
        logic ren;
    } tbl_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

### src/hash_join_match_table.sv
// Hash join match table: top level with control sequencer and result register.
// Insert, clear: one transfer per cycle unless results stall, result registered in
// the cycle after the transfer. Probe: a scan and a flush, neither on an empty table;
// the single read port of the entry memory scans one entry per cycle, pausing on stall.
// Reset clears the entry count and control state; memory contents are left as they are.
`timescale 1ns / 1ps
module hash_join_match_table #(
    parameter int TABLE_DEPTH = hjm_pkg::HJM_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  hjm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output hjm_pkg::result_t result
);
    import hjm_pkg::*;

    `include "hash_join_match_table_macros.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [63:0]       key_reg, key_next;
    logic [15:0]       rid_reg, rid_next;
    logic [15:0]       pend_id_reg, pend_id_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    tbl_ctl_t          tbl_ctl;
    entry_t            tbl_wdata;
    entry_t            tbl_rdata;

    logic              out_load;
    logic              item_fire;
    logic              hit;
    logic              scan_go;
    logic              last_idx;
    logic              full;

    hjm_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .ctl   (tbl_ctl),
        .waddr (entry_count_reg[IDX_W-1:0]),
        .wdata (tbl_wdata),
        .raddr (rd_idx_next),
        .rdata (tbl_rdata)
    );

    assign out_load   = !result_valid_reg || !result_stall;
    assign item_stall = !(state_reg == ST_IDLE && out_load);
    assign item_fire  = item_valid && !item_stall;
    assign hit        = tbl_rdata.key_hash == key_reg;
    assign scan_go    = (state_reg == ST_SCAN) && !(hit && pend_valid_reg && !out_load);
    assign last_idx   = (CNT_W'(rd_idx_reg) + 1'b1) == entry_count_reg;
    assign full       = entry_count_reg == CNT_W'(TABLE_DEPTH);
    assign tbl_wdata  = '{key_hash: item.key_hash, region_id: item.region_id};

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && item.action == ACT_PROBE && entry_count_reg != '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_go && last_idx)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        entry_count_next  = entry_count_reg;
        rd_idx_next       = rd_idx_reg;
        key_next          = key_reg;
        rid_next          = rid_reg;
        pend_id_next      = pend_id_reg;
        pend_valid_next   = pend_valid_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        tbl_ctl           = '{wen: 1'b0, ren: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    key_next = item.key_hash;
                    rid_next = item.region_id;
                    case (item.action)
                        ACT_INSERT:
                        begin
                            result_valid_next = 1'b1;
                            result_next = '{status: full ? RS_FULL : RS_STORED,
                                            delete_id: 16'd0, insert_id: 16'd0,
                                            last_result: 1'b1};
                            if (!full)
                            begin
                                tbl_ctl.wen      = 1'b1;
                                entry_count_next = entry_count_reg + 1'b1;
                            end
                        end
                        ACT_PROBE:
                        begin
                            pend_valid_next = 1'b0;
                            if (entry_count_reg == '0)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{status: RS_NOMATCH,
                                                delete_id: item.region_id,
                                                insert_id: 16'd0, last_result: 1'b1};
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                tbl_ctl.ren = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            entry_count_next  = '0;
                            result_valid_next = 1'b1;
                            result_next = '{status: RS_CLEARED, delete_id: 16'd0,
                                            insert_id: 16'd0, last_result: 1'b1};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    if (hit)
                    begin
                        // hold one match back so the final one can carry the last mark
                        if (pend_valid_reg)
                        begin
                            result_valid_next = 1'b1;
                            result_next = '{status: RS_MATCH, delete_id: rid_reg,
                                            insert_id: pend_id_reg, last_result: 1'b0};
                        end
                        pend_id_next    = tbl_rdata.region_id;
                        pend_valid_next = 1'b1;
                    end
                    if (!last_idx)
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        tbl_ctl.ren = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_load)
                begin
                    result_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        result_next = '{status: RS_MATCH, delete_id: rid_reg,
                                        insert_id: pend_id_reg, last_result: 1'b1};
                    end
                    else
                    begin
                        result_next = '{status: RS_NOMATCH, delete_id: rid_reg,
                                        insert_id: 16'd0, last_result: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            entry_count_reg  <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        key_reg     <= key_next;
        rid_reg     <= rid_next;
        pend_id_reg <= pend_id_next;
        result_reg  <= result_next;
    end

    `HJM_ASSERT(a_count_bound, entry_count_reg <= CNT_W'(TABLE_DEPTH))
    `HJM_ASSERT(a_scan_in_range, state_reg == ST_SCAN |-> CNT_W'(rd_idx_reg) < entry_count_reg)
    `HJM_ASSERT_NEXT(a_insert_grows, item_fire && item.action == ACT_INSERT && !full, entry_count_reg == $past(entry_count_reg) + 1'b1)
    `HJM_ASSERT_NEXT(a_flush_ends, state_reg == ST_FLUSH && out_load, state_reg == ST_IDLE && result_valid_reg && result_reg.last_result)

endmodule

### src/hjm_table.sv
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module hjm_table #(
    parameter int DEPTH = hjm_pkg::HJM_DEPTH
) (
    input  logic                     clk,
    input  hjm_pkg::tbl_ctl_t        ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  hjm_pkg::entry_t          wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output hjm_pkg::entry_t          rdata
);
    import hjm_pkg::*;

    entry_t table_mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wen)
        begin
            table_mem[waddr] <= wdata;
        end
        if (ctl.ren)
        begin
            rdata_reg <= table_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sim/tb_top.sv
// Testbench for the hash join match table: directed items and random join rounds checked by a scoreboard.
`timescale 1ns / 1ps

class join_scoreboard;
    hjm_pkg::result_t expected_q[$];
    logic [63:0]      key_mem[hjm_pkg::HJM_DEPTH];
    logic [15:0]      rid_mem[hjm_pkg::HJM_DEPTH];
    int               fill;
    int               errors;
    int               checked;
    int               match_count;
    int               drops;

    function new();
        fill        = 0;
        errors      = 0;
        checked     = 0;
        match_count = 0;
        drops       = 0;
    endfunction

    function void push_result(logic [2:0] st, logic [15:0] del, logic [15:0] ins,
                              logic last);
        hjm_pkg::result_t r;
        r.status      = st;
        r.delete_id   = del;
        r.insert_id   = ins;
        r.last_result = last;
        expected_q = {expected_q, r};
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Predicts the results of one accepted input transfer.
    function void note_item(hjm_pkg::item_t it);
        int hits;
        int k;
        hits = 0;
        k    = 0;
        case (it.action)
            hjm_pkg::ACT_INSERT:
            begin
                if (fill < hjm_pkg::HJM_DEPTH)
                begin
                    key_mem[fill] = it.key_hash;
                    rid_mem[fill] = it.region_id;
                    fill++;
                    push_result(hjm_pkg::RS_STORED, 16'd0, 16'd0, 1'b1);
                end
                else
                begin
                    drops++;
                    push_result(hjm_pkg::RS_FULL, 16'd0, 16'd0, 1'b1);
                end
            end
            hjm_pkg::ACT_PROBE:
            begin
                for (int i = 0; i < fill; i++)
                    if (key_mem[i] == it.key_hash)
                        hits++;
                if (hits == 0)
                    push_result(hjm_pkg::RS_NOMATCH, it.region_id, 16'd0, 1'b1);
                for (int i = 0; i < fill; i++)
                begin
                    if (key_mem[i] == it.key_hash)
                    begin
                        k++;
                        push_result(hjm_pkg::RS_MATCH, it.region_id, rid_mem[i], k == hits);
                    end
                end
            end
            hjm_pkg::ACT_CLEAR:
            begin
                fill = 0;
                push_result(hjm_pkg::RS_CLEARED, 16'd0, 16'd0, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_result(hjm_pkg::result_t got);
        hjm_pkg::result_t exp_r;
        if (expected_q.size() == 0)
        begin
            $error("result transfer with nothing expected: status %0d", got.status);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        checked++;
        if (exp_r.status == hjm_pkg::RS_MATCH)
            match_count++;
        if (got.status !== exp_r.status)
        begin
            $error("status: expected %0d, actual %0d", exp_r.status, got.status);
            errors++;
        end
        if (got.delete_id !== exp_r.delete_id)
        begin
            $error("delete_id: expected %0h, actual %0h", exp_r.delete_id, got.delete_id);
            errors++;
        end
        if (got.insert_id !== exp_r.insert_id)
        begin
            $error("insert_id: expected %0h, actual %0h", exp_r.insert_id, got.insert_id);
            errors++;
        end
        if (got.last_result !== exp_r.last_result)
        begin
            $error("last_result: expected %0b, actual %0b", exp_r.last_result,
                   got.last_result);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import hjm_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         DEPTH        = HJM_DEPTH;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = DEPTH + 16;
    localparam int         PHASE_ITEMS  = 16;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    join_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycles;
    int join_items;

    hash_join_match_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (cycles > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycles,
                   sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t build_item(logic [1:0] act, logic [63:0] key, logic [15:0] id);
        item_t it;
        it.action    = act;
        it.key_hash  = key;
        it.region_id = id;
        return it;
    endfunction

    // Entered and left at a falling edge; valid is left high on return.
    task automatic send_item(item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        if (it.action != ACT_UNUSED)
            join_items++;
        @(negedge clk);
    endtask

    task automatic send(logic [1:0] act, logic [63:0] key, logic [15:0] id);
        send_item(build_item(act, key, id));
    endtask

    // Mostly a clear, then build side, then probe side; with some noise and out-of-order items.
    task automatic join_round(int n_ins, int n_keys);
        logic [63:0] pool[8];
        int          n_probe;
        for (int i = 0; i < 8; i++)
            pool[i] = rand_key();
        if ($urandom_range(7) == 0)
            pool[0] = '1;
        if ($urandom_range(7) == 0)
            pool[n_keys - 1] = '0;
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 4))
                send(2'($urandom_range(3)), pool[$urandom_range(n_keys - 1)],
                     16'($urandom_range(65535)));
        if ($urandom_range(9) < 8)
            send(ACT_CLEAR, rand_key(), 16'($urandom_range(65535)));
        repeat (n_ins)
        begin
            if ($urandom_range(19) == 0)
                send(ACT_UNUSED, rand_key(), 16'($urandom_range(65535)));
            else if ($urandom_range(24) == 0)
                send(ACT_PROBE, pool[$urandom_range(n_keys - 1)], 16'($urandom_range(65535)));
            send(ACT_INSERT, pool[$urandom_range(n_keys - 1)], 16'($urandom_range(65535)));
        end
        n_probe = $urandom_range(2, 6);
        repeat (n_probe)
        begin
            if ($urandom_range(4) == 0)
                send(ACT_PROBE, rand_key(), 16'($urandom_range(65535)));
            else
                send(ACT_PROBE, pool[$urandom_range(n_keys - 1)], 16'($urandom_range(65535)));
        end
    endtask

    initial
    begin
        int target;
        sb                 = new();
        rst_n              = 1'b0;
        item_valid         = 1'b0;
        item               = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        join_items         = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty probe, extremes, duplicate hashes and ids, ignored action
        send(ACT_PROBE,  64'd0,                  16'd0);
        send(ACT_INSERT, '1,                     16'hFFFF);
        send(ACT_INSERT, 64'd0,                  16'd0);
        send(ACT_INSERT, '1,                     16'h1234);
        send(ACT_INSERT, '1,                     16'hFFFF);
        send(ACT_PROBE,  '1,                     16'hABCD);
        send(ACT_PROBE,  64'd0,                  16'hFFFF);
        send(ACT_PROBE,  64'd1,                  16'h0001);
        send(ACT_UNUSED, '1,                     16'hFFFF);
        send(ACT_CLEAR,  '1,                     16'hFFFF);
        send(ACT_PROBE,  '1,                     16'h5555);
        send(ACT_CLEAR,  64'd0,                  16'd0);
        send(ACT_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
        send(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 16'h7FFF);
        send(ACT_PROBE,  64'h8000_0000_0000_0000, 16'h7FFF);
        send(ACT_PROBE,  64'h7FFF_FFFF_FFFF_FFFF, 16'h8000);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 75;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 75;
                end
                default:
                begin
                    sender_idle_pct    = 10;
                    receiver_stall_pct = 10;
                end
            endcase
            target = join_items + PHASE_ITEMS;
            if (ph == 2)
                join_round(DEPTH + $urandom_range(1, 3), $urandom_range(1, 2));
            while (join_items < target)
                join_round($urandom_range(1, 12), $urandom_range(1, 6));
        end

        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d item transfers over four pressure phases, %0d dropped %s",
                 join_items, sb.drops, "on a full table.");
        $display("Checked %0d result transfers, %0d of them matches.", sb.checked,
                 sb.match_count);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/hjm_pkg.sv
src/hjm_table.sv
src/hash_join_match_table.sv
sim/tb_top.sv
